@@ design/rvdec_pkg.sv @@
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared codes and types for the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

	localparam int unsigned XLEN = 32;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_UNK_FN = 2'd1;
	localparam logic [1:0] STAT_BAD_OP = 2'd2;

	// major opcodes
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_SYSTEM = 7'b1110011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_FENCE  = 7'b0001111;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	// exact system encodings
	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

	// mnemonic codes; ranges are indexed by funct3
	localparam logic [5:0] MN_NONE    = 6'd0;
	localparam logic [5:0] MN_ECALL   = 6'd1;
	localparam logic [5:0] MN_EBREAK  = 6'd2;
	localparam logic [5:0] MN_ADD     = 6'd3;
	localparam logic [5:0] MN_SUB     = 6'd11;
	localparam logic [5:0] MN_SRA     = 6'd12;
	localparam logic [5:0] MN_MUL     = 6'd13;
	localparam logic [5:0] MN_CSRRW   = 6'd21;
	localparam logic [5:0] MN_CSRRWI  = 6'd24;
	localparam logic [5:0] MN_LB      = 6'd27;
	localparam logic [5:0] MN_LBU     = 6'd30;
	localparam logic [5:0] MN_LHU     = 6'd31;
	localparam logic [5:0] MN_SB      = 6'd32;
	localparam logic [5:0] MN_BEQ     = 6'd35;
	localparam logic [5:0] MN_BLT     = 6'd37;
	localparam logic [5:0] MN_LUI     = 6'd41;
	localparam logic [5:0] MN_AUIPC   = 6'd42;
	localparam logic [5:0] MN_ADDI    = 6'd43;
	localparam logic [5:0] MN_SLLI    = 6'd44;
	localparam logic [5:0] MN_SLTI    = 6'd45;
	localparam logic [5:0] MN_SLTIU   = 6'd46;
	localparam logic [5:0] MN_XORI    = 6'd47;
	localparam logic [5:0] MN_SRLI    = 6'd48;
	localparam logic [5:0] MN_SRAI    = 6'd49;
	localparam logic [5:0] MN_ORI     = 6'd50;
	localparam logic [5:0] MN_ANDI    = 6'd51;
	localparam logic [5:0] MN_JAL     = 6'd52;
	localparam logic [5:0] MN_JALR    = 6'd53;
	localparam logic [5:0] MN_FENCE   = 6'd54;
	localparam logic [5:0] MN_FENCE_I = 6'd55;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         mnemonic;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic [11:0]        csr_number;
		logic signed [31:0] immediate;
		logic [31:0]        target_address;
	} dec_res_t;

endpackage

@@ design/rvdec_in_if.sv @@
// ----------------------------------------------------------------------------
// rvdec_in_if
// Instruction channel: valid/ready handshake with word and address.
// ----------------------------------------------------------------------------
interface rvdec_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;
	logic [31:0] instruction_address;

	modport source (output valid, output instruction_word, output instruction_address,
		input ready);
	modport sink (input valid, input instruction_word, input instruction_address,
		output ready);
endinterface

@@ design/rvdec_out_if.sv @@
// ----------------------------------------------------------------------------
// rvdec_out_if
// Decode result channel: valid/ready handshake with decoded fields.
// ----------------------------------------------------------------------------
interface rvdec_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [5:0]         mnemonic;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [11:0]        csr_number;
	logic signed [31:0] immediate;
	logic [31:0]        target_address;

	modport source (output valid, output status, output mnemonic, output dest_reg,
		output src1_reg, output src2_reg, output csr_number, output immediate,
		output target_address, input ready);
	modport sink (input valid, input status, input mnemonic, input dest_reg,
		input src1_reg, input src2_reg, input csr_number, input immediate,
		input target_address, output ready);
endinterface

@@ design/rv32im_instruction_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_unit
// RV32IM instruction decoder with registered input and result stages.
// ----------------------------------------------------------------------------
// Takes one instruction word and address per transaction and returns one
// result per transaction, in order. Throughput is one instruction per clock
// while the output channel is ready; a result passes from the input register
// through the combinational decode into the result register before it is
// presented on the output channel. Each stage accepts new data whenever it
// is empty or its contents move on in the same cycle, so a stalled output
// still lets one further instruction enter the input stage.
module rv32im_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	rvdec_in_if.sink    instr,
	rvdec_out_if.source result
);

	logic                valid_s1;
	logic [31:0]         word_s1;
	logic [31:0]         addr_s1;
	logic                valid_s2;
	rvdec_pkg::dec_res_t res_s2;
	rvdec_pkg::dec_res_t dec_res;
	logic                adv_s2;
	logic                adv_s1;

	assign adv_s2      = !valid_s2 || result.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign instr.ready = adv_s1;

	rvdec_core u_core (
		.word (word_s1),
		.addr (addr_s1),
		.res  (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= instr.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && instr.valid) begin
			word_s1 <= instr.instruction_word;
			addr_s1 <= instr.instruction_address;
		end
		if (adv_s2 && valid_s1)
			res_s2 <= dec_res;
	end

	assign result.valid          = valid_s2;
	assign result.status         = res_s2.status;
	assign result.mnemonic       = res_s2.mnemonic;
	assign result.dest_reg       = res_s2.dest_reg;
	assign result.src1_reg       = res_s2.src1_reg;
	assign result.src2_reg       = res_s2.src2_reg;
	assign result.csr_number     = res_s2.csr_number;
	assign result.immediate      = res_s2.immediate;
	assign result.target_address = res_s2.target_address;

endmodule

@@ design/rvdec_core.sv @@
// ----------------------------------------------------------------------------
// rvdec_core
// Combinational decode of one instruction word: class, fields, immediate
// and branch/jal target.
// ----------------------------------------------------------------------------
module rvdec_core (
	input  logic [31:0]          word,
	input  logic [31:0]          addr,
	output rvdec_pkg::dec_res_t  res
);

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [5:0]  f3_ext;

	logic [1:0]  st;
	logic [5:0]  mn;
	logic [11:0] csr;
	logic [31:0] imm;
	logic        has_tgt;

	assign op     = word[6:0];
	assign f3     = word[14:12];
	assign f7     = word[31:25];
	assign rd     = word[11:7];
	assign rs1    = word[19:15];
	assign rs2    = word[24:20];
	assign f3_ext = {3'b000, f3};

	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
	assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
	assign imm_u = {word[31:12], 12'h000};

	always_comb begin
		st      = rvdec_pkg::STAT_OK;
		mn      = rvdec_pkg::MN_NONE;
		csr     = 12'h000;
		imm     = 32'h0000_0000;
		has_tgt = 1'b0;

		unique case (op)
			rvdec_pkg::OP_REG: begin
				if (f7 == rvdec_pkg::F7_BASE)
					mn = rvdec_pkg::MN_ADD + f3_ext;
				else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0)
					mn = rvdec_pkg::MN_SUB;
				else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5)
					mn = rvdec_pkg::MN_SRA;
				else if (f7 == rvdec_pkg::F7_MULDIV)
					mn = rvdec_pkg::MN_MUL + f3_ext;
			end
			rvdec_pkg::OP_SYSTEM: begin
				if (word == rvdec_pkg::WORD_ECALL)
					mn = rvdec_pkg::MN_ECALL;
				else if (word == rvdec_pkg::WORD_EBREAK)
					mn = rvdec_pkg::MN_EBREAK;
				else if (f3[1:0] != 2'b00) begin
					csr = word[31:20];
					if (f3[2]) begin
						mn  = rvdec_pkg::MN_CSRRWI + {4'b0000, f3[1:0]} - 6'd1;
						imm = {27'd0, rs1};
					end else begin
						mn = rvdec_pkg::MN_CSRRW + {4'b0000, f3[1:0]} - 6'd1;
					end
				end
			end
			rvdec_pkg::OP_LOAD: begin
				if (f3 <= 3'd2)
					mn = rvdec_pkg::MN_LB + f3_ext;
				else if (f3 == 3'd4)
					mn = rvdec_pkg::MN_LBU;
				else if (f3 == 3'd5)
					mn = rvdec_pkg::MN_LHU;
				imm = imm_i;
			end
			rvdec_pkg::OP_STORE: begin
				if (f3 <= 3'd2)
					mn = rvdec_pkg::MN_SB + f3_ext;
				imm = imm_s;
			end
			rvdec_pkg::OP_BRANCH: begin
				if (f3 <= 3'd1)
					mn = rvdec_pkg::MN_BEQ + f3_ext;
				else if (f3[2])
					mn = rvdec_pkg::MN_BLT + {4'b0000, f3[1:0]};
				imm     = imm_b;
				has_tgt = 1'b1;
			end
			rvdec_pkg::OP_LUI: begin
				mn  = rvdec_pkg::MN_LUI;
				imm = imm_u;
			end
			rvdec_pkg::OP_AUIPC: begin
				mn  = rvdec_pkg::MN_AUIPC;
				imm = imm_u;
			end
			rvdec_pkg::OP_IMM: begin
				imm = imm_i;
				unique case (f3)
					3'd0: mn = rvdec_pkg::MN_ADDI;
					3'd1: begin
						if (f7 == rvdec_pkg::F7_BASE)
							mn = rvdec_pkg::MN_SLLI;
						imm = {27'd0, rs2};
					end
					3'd2: mn = rvdec_pkg::MN_SLTI;
					3'd3: mn = rvdec_pkg::MN_SLTIU;
					3'd4: mn = rvdec_pkg::MN_XORI;
					3'd5: begin
						if (f7 == rvdec_pkg::F7_BASE)
							mn = rvdec_pkg::MN_SRLI;
						else if (f7 == rvdec_pkg::F7_ALT)
							mn = rvdec_pkg::MN_SRAI;
						imm = {27'd0, rs2};
					end
					3'd6: mn = rvdec_pkg::MN_ORI;
					default: mn = rvdec_pkg::MN_ANDI;
				endcase
			end
			rvdec_pkg::OP_JAL: begin
				mn      = rvdec_pkg::MN_JAL;
				imm     = imm_j;
				has_tgt = 1'b1;
			end
			rvdec_pkg::OP_JALR: begin
				if (f3 == 3'd0)
					mn = rvdec_pkg::MN_JALR;
				imm = imm_i;
			end
			rvdec_pkg::OP_FENCE: begin
				if (f3 == 3'd0)
					mn = rvdec_pkg::MN_FENCE;
				else if (f3 == 3'd1)
					mn = rvdec_pkg::MN_FENCE_I;
			end
			default: st = rvdec_pkg::STAT_BAD_OP;
		endcase

		if (st == rvdec_pkg::STAT_OK && mn == rvdec_pkg::MN_NONE)
			st = rvdec_pkg::STAT_UNK_FN;
		if (st != rvdec_pkg::STAT_OK) begin
			mn      = rvdec_pkg::MN_NONE;
			csr     = 12'h000;
			imm     = 32'h0000_0000;
			has_tgt = 1'b0;
		end
	end

	always_comb begin
		res.status         = st;
		res.mnemonic       = mn;
		res.dest_reg       = rd;
		res.src1_reg       = rs1;
		res.src2_reg       = rs2;
		res.csr_number     = csr;
		res.immediate      = imm;
		res.target_address = has_tgt ? addr + imm : 32'h0000_0000;
	end

endmodule
